// ----- hw/rtl/ile_pkg.sv -----
// Package for the indexed list engine: operation codes, position width and
// the per-cell shift control type. No dependencies.
`timescale 1ns / 1ps

package ile_pkg;

  localparam int POS_W = 6;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_GET    = 2'd2;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/indexed_list_engine_top.sv -----
// Indexed list engine: an ordered list held in a chain of ile_cell stages.
// An accepted item's result is captured in the output register, and all
// cells it moves shift at once. One item per cycle unless out_ready stalls.
// Reset clears the entry count and the output valid; cell words are not
// cleared, since an entry is only read after an insert has written it.
`timescale 1ns / 1ps

module indexed_list_engine_top
  import ile_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          op,
  input  logic signed [POS_W-1:0]             position,
  input  logic [DATA_WIDTH-1:0]               data_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                ok,
  output logic [DATA_WIDTH-1:0]               data_out,
  output logic [$clog2(CAPACITY + 1)-1:0]     length
);

  localparam int LEN_W = $clog2(CAPACITY + 1);
  localparam int IW    = ((LEN_W > POS_W) ? LEN_W : POS_W) + 2;
  localparam logic [LEN_W-1:0] CAP_L = LEN_W'(CAPACITY);

  logic [LEN_W-1:0]        count;
  logic [LEN_W-1:0]        count_next;
  logic                    in_fire;
  logic signed [IW-1:0]    pos_x;
  logic signed [IW-1:0]    len_x;
  logic signed [IW-1:0]    idx_ins;
  logic signed [IW-1:0]    idx_rd;
  logic                    is_rd;
  logic                    ins_ok;
  logic                    rd_ok;
  logic [LEN_W-1:0]        cell_idx;
  logic [DATA_WIDTH-1:0]   rd_word;
  cell_ctl_t               ctl;
  logic [DATA_WIDTH-1:0]   word [CAPACITY];

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign pos_x   = IW'(position);
  assign len_x   = $signed({{(IW - LEN_W){1'b0}}, count});
  assign idx_ins = position[POS_W-1] ? (len_x + IW'(1) + pos_x) : pos_x;
  assign idx_rd  = position[POS_W-1] ? (len_x + pos_x) : pos_x;
  assign is_rd   = (op == OP_REMOVE) || (op == OP_GET);

  assign ins_ok = (op == OP_INSERT) && (idx_ins >= 0) && (idx_ins <= len_x)
                  && (count < CAP_L);
  assign rd_ok  = is_rd && (idx_rd >= 0) && (idx_rd < len_x);

  assign cell_idx = (op == OP_INSERT) ? idx_ins[LEN_W-1:0] : idx_rd[LEN_W-1:0];

  assign ctl.ins = in_fire && ins_ok;
  assign ctl.rem = in_fire && rd_ok && (op == OP_REMOVE);

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_w;
      logic [DATA_WIDTH-1:0] right_w;
      if (g == 0) begin : g_first
        assign left_w = '0;
      end else begin : g_mid_l
        assign left_w = word[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign right_w = '0;
      end else begin : g_mid_r
        assign right_w = word[g+1];
      end
      ile_cell #(
        .INDEX      (g),
        .LEN_W      (LEN_W),
        .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .idx     (cell_idx),
        .len     (count),
        .data_in (data_in),
        .left    (left_w),
        .right   (right_w),
        .word    (word[g])
      );
    end
  endgenerate

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_idx == LEN_W'(i)) begin
        rd_word = rd_word | word[i];
      end
    end
  end

  always_comb begin
    count_next = count;
    if (ctl.ins) begin
      count_next = count + LEN_W'(1);
    end else if (ctl.rem) begin
      count_next = count - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (in_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ok       <= ins_ok || rd_ok;
      data_out <= rd_ok ? rd_word : '0;
      length   <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_L)
    else $error("entry count above capacity");

  a_len_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> length == count)
    else $error("result length differs from entry count");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ctl.ins |=> count == $past(count) + LEN_W'(1))
    else $error("insert did not grow the list");

  a_get_holds: assert property (@(posedge clk) disable iff (rst)
    in_fire && (op == OP_GET) |=> $stable(count))
    else $error("get changed the entry count");

  a_fail_holds: assert property (@(posedge clk) disable iff (rst)
    in_fire && !ins_ok && !rd_ok |=> $stable(count))
    else $error("failed item changed the entry count");

endmodule

// ----- hw/rtl/ile_cell.sv -----
// One list chain cell: holds the entry at a fixed position and takes data_in
// or the left neighbor's word on insert, the right on remove. Uses ile_pkg.
`timescale 1ns / 1ps

module ile_cell
  import ile_pkg::*;
#(
  parameter int INDEX      = 0,
  parameter int LEN_W      = 5,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic [LEN_W-1:0]      idx,
  input  logic [LEN_W-1:0]      len,
  input  logic [DATA_WIDTH-1:0] data_in,
  input  logic [DATA_WIDTH-1:0] left,
  input  logic [DATA_WIDTH-1:0] right,
  output logic [DATA_WIDTH-1:0] word
);

  localparam logic [LEN_W-1:0] SELF     = LEN_W'(INDEX);
  localparam logic [LEN_W:0]   NEXT_POS = (LEN_W + 1)'(INDEX + 1);

  logic [DATA_WIDTH-1:0] word_next;

  always_comb begin
    word_next = word;
    if (ctl.ins) begin
      if (SELF == idx) begin
        word_next = data_in;
      end else if (SELF > idx && SELF <= len) begin
        word_next = left;
      end
    end else if (ctl.rem) begin
      if (SELF >= idx && NEXT_POS < {1'b0, len}) begin
        word_next = right;
      end
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

// ----- tb/indexed_list_checker.sv -----
// Checker for the indexed list engine: watches both channels, keeps its own copy
// of the list, predicts each result and compares ok, data_out and length.
// Depends on ile_pkg for the operation codes and the position width.
`timescale 1ns / 1ps

module indexed_list_checker
  import ile_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [1:0]                          op,
  input  logic signed [POS_W-1:0]             position,
  input  logic [DATA_WIDTH-1:0]               data_in,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                ok,
  input  logic [DATA_WIDTH-1:0]               data_out,
  input  logic [$clog2(CAPACITY + 1)-1:0]     length,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  results_seen,
  output int                                  len_hint
);

  localparam int LEN_W = $clog2(CAPACITY + 1);

  typedef struct packed {
    logic                  ok;
    logic [DATA_WIDTH-1:0] word;
    logic [LEN_W-1:0]      len;
  } list_result_t;

  logic [DATA_WIDTH-1:0] list_words [CAPACITY];
  int                    list_count;
  list_result_t          result_q [$];
  list_result_t          head;
  list_result_t          fresh;

  task automatic apply_op(input logic [1:0] code, input logic signed [POS_W-1:0] pos,
                          input logic [DATA_WIDTH-1:0] word, output list_result_t res);
    int idx;
    int i;
    res = '0;
    case (code)
      OP_INSERT: begin
        idx = (pos < 0) ? list_count + 1 + int'(pos) : int'(pos);
        if (idx >= 0 && idx <= list_count && list_count < CAPACITY) begin
          for (i = list_count; i > idx; i--) list_words[i] = list_words[i-1];
          list_words[idx] = word;
          list_count++;
          res.ok = 1'b1;
        end
      end
      OP_REMOVE, OP_GET: begin
        idx = (pos < 0) ? list_count + int'(pos) : int'(pos);
        if (idx >= 0 && idx < list_count) begin
          res.word = list_words[idx];
          if (code == OP_REMOVE) begin
            for (i = idx; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
            list_count--;
          end
          res.ok = 1'b1;
        end
      end
      default: ;
    endcase
    res.len = LEN_W'(list_count);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      list_count = 0;
      result_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (result_q.size() == 0) begin
          fail_count++;
          $error("unexpected result: ok=%0d data_out=%h length=%0d", ok, data_out, length);
        end else begin
          head = result_q.pop_front();
          if (ok !== head.ok) begin
            fail_count++;
            $error("ok mismatch: expected %0d, actual %0d", head.ok, ok);
          end
          if (data_out !== head.word) begin
            fail_count++;
            $error("data_out mismatch: expected %h, actual %h", head.word, data_out);
          end
          if (length !== head.len) begin
            fail_count++;
            $error("length mismatch: expected %0d, actual %0d", head.len, length);
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_op(op, position, data_in, fresh);
        result_q.push_back(fresh);
      end
    end
    pending  <= result_q.size();
    len_hint <= list_count;
  end

endmodule

// ----- tb/indexed_list_engine_top_tb.sv -----
// Testbench top for indexed_list_engine_top: clock, reset, directed and random
// list operations with random idling on both channels, and the final verdict.
// Depends on ile_pkg, indexed_list_engine_top and indexed_list_checker.
`timescale 1ns / 1ps

module indexed_list_engine_top_tb;
  import ile_pkg::*;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int LEN_W      = $clog2(CAPACITY + 1);
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1050;
  localparam int EPISODE      = 50;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [1:0]             op = OP_INSERT;
  logic signed [POS_W-1:0] position = '0;
  logic [DATA_WIDTH-1:0]  data_in = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   ok;
  logic [DATA_WIDTH-1:0]  data_out;
  logic [LEN_W-1:0]       length;
  logic                   calm = 1'b0;

  int fail_count;
  int pending;
  int results_seen;
  int len_hint;
  int op_sent [4];

  indexed_list_engine_top #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .position (position),
    .data_in  (data_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .ok       (ok),
    .data_out (data_out),
    .length   (length)
  );

  indexed_list_checker #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .position    (position),
    .data_in     (data_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ok          (ok),
    .data_out    (data_out),
    .length      (length),
    .fail_count  (fail_count),
    .pending     (pending),
    .results_seen(results_seen),
    .len_hint    (len_hint)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 12);
  end

  task automatic hold_off();
    if (!calm && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic send_item(input logic [1:0] code, input int pos,
                           input logic [DATA_WIDTH-1:0] word);
    in_valid <= 1'b1;
    op       <= code;
    position <= pos[POS_W-1:0];
    data_in  <= word;
    do @(posedge clk); while (!in_ready);
    op_sent[code]++;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic int pick_position(logic [1:0] code, int len);
    int r;
    int idx;
    r = $urandom_range(0, 99);
    if (r < 82) begin
      if (code == OP_INSERT) begin
        idx = $urandom_range(0, len);
        return $urandom_range(0, 1) ? idx - (len + 1) : idx;
      end
      if (len == 0) return $urandom_range(0, 1) ? 0 : -1;
      idx = $urandom_range(0, len - 1);
      return $urandom_range(0, 1) ? idx - len : idx;
    end
    if (r < 92) return int'($urandom_range(0, 33)) - 17;
    return int'($urandom_range(0, 63)) - 32;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return DATA_WIDTH'($urandom);
  endfunction

  function automatic logic [1:0] pick_op(int mode);
    int r;
    int ins_w;
    int rem_w;
    r = $urandom_range(0, 99);
    case (mode)
      0: begin ins_w = 70; rem_w = 15; end
      1: begin ins_w = 20; rem_w = 60; end
      2: begin ins_w = 40; rem_w = 25; end
      default: begin ins_w = 25; rem_w = 15; end
    endcase
    if (r < 2) return OP_UNUSED;
    if (r < 2 + ins_w) return OP_INSERT;
    if (r < 2 + ins_w + rem_w) return OP_REMOVE;
    return OP_GET;
  endfunction

  initial begin
    logic [1:0] code;
    int episode;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_item(OP_GET,    0,  32'h1111_1111);
    send_item(OP_REMOVE, -1, 32'h2222_2222);
    send_item(OP_INSERT, -1, 32'h0000_0000);
    send_item(OP_INSERT, 0,  32'hFFFF_FFFF);
    send_item(OP_INSERT, 2,  32'hA5A5_A5A5);
    hold_off();
    send_item(OP_INSERT, 4,  32'h0BAD_0BAD);
    send_item(OP_INSERT, -5, 32'h0BAD_0BAD);
    send_item(OP_INSERT, -4, 32'h5A5A_5A5A);
    send_item(OP_INSERT, 31, 32'h0BAD_0BAD);
    send_item(OP_INSERT, -32, 32'h0BAD_0BAD);
    hold_off();
    send_item(OP_GET,    -1, 32'hFFFF_FFFF);
    send_item(OP_GET,    0,  32'h0);
    send_item(OP_GET,    4,  32'h0);
    send_item(OP_GET,    -5, 32'h0);
    send_item(OP_GET,    -4, 32'h0);
    send_item(OP_REMOVE, 1,  32'h0);
    send_item(OP_UNUSED, 0,  32'h0000_0001);
    send_item(OP_REMOVE, -1, 32'h0);
    send_item(OP_REMOVE, 0,  32'h0);
    send_item(OP_REMOVE, -1, 32'h0);
    send_item(OP_REMOVE, 0,  32'h0);
    send_item(OP_GET,    31, 32'h0);
    send_item(OP_REMOVE, -32, 32'h0);
    in_valid <= 1'b0;
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      episode = n / EPISODE;
      if (n % EPISODE == 0) begin
        calm <= (episode == 5 || episode == 6);
        if (episode == 3 || episode == 12) begin
          in_valid <= 1'b0;
          wait_drained();
        end
      end
      hold_off();
      code = pick_op(episode % 4);
      send_item(code, pick_position(code, len_hint), pick_word());
    end
    in_valid <= 1'b0;

    wait_drained();
    repeat (4) @(posedge clk);
    $display("covered %0d inserts, %0d removes, %0d gets and %0d unused-op items;",
             op_sent[OP_INSERT], op_sent[OP_REMOVE], op_sent[OP_GET], op_sent[OP_UNUSED]);
    $display("%0d results compared, %0d field mismatches", results_seen, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("indexed_list_engine_top regression: pass");
    end else begin
      $display("indexed_list_engine_top regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("indexed_list_engine_top regression: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/ile_pkg.sv
hw/rtl/ile_cell.sv
hw/rtl/indexed_list_engine_top.sv
tb/indexed_list_checker.sv
tb/indexed_list_engine_top_tb.sv
